>>> sv/vasd_pkg.sv
// Shared types, opcodes and level conversion functions for the volume attenuator driver.
package vasd_pkg;

	typedef enum logic [2:0] {
		OP_SERIAL_TICK = 3'd0,
		OP_LOUDER      = 3'd1,
		OP_QUIETER     = 3'd2,
		OP_TEMP_ATTEN  = 3'd3,
		OP_MS_TICK     = 3'd4,
		OP_SET_LEVEL   = 3'd5
	} vasd_op_t;

	localparam logic [7:0]  LEVEL_MUTE      = 8'd128;
	localparam logic [7:0]  LEVEL_FINE_TOP  = 8'd96;
	localparam logic [7:0]  LEVEL_COARSE_TOP = 8'd127;
	localparam logic [8:0]  HALF_DB_MUTE    = 9'd200;
	localparam logic [9:0]  HALF_DB_LIMIT   = 10'd156;
	localparam logic [15:0] MS_COUNT_MAX    = 16'hFFFF;
	localparam logic [15:0] TIMEOUT_RESET   = 16'd5000;
	localparam logic [8:0]  FIRST_FRAME_TAG = 9'h100;

	// Shifter command from the level logic.
	typedef struct packed {
		logic       tick;
		logic       start;
		logic [7:0] code;
	} vasd_shift_ctrl_t;

	// Pin levels and busy flag after the current item.
	typedef struct packed {
		logic clock_pin;
		logic data_pin;
		logic load_pin;
		logic busy;
	} vasd_shift_stat_t;

	// Attenuation code to half-dB units.
	function automatic logic [8:0] code_to_half_db(input logic [7:0] code);
		logic [8:0] r;
		if (code <= LEVEL_FINE_TOP) begin
			r = {1'b0, code};
		end else if (code <= LEVEL_COARSE_TOP) begin
			r = {code, 1'b0} - 9'(LEVEL_FINE_TOP);
		end else begin
			r = HALF_DB_MUTE;
		end
		return r;
	endfunction

	// Signed half-dB sum back to a code; truncate in the 1 dB region.
	function automatic logic [7:0] half_db_to_code(input logic signed [9:0] s);
		logic [9:0] u;
		logic [7:0] r;
		u = $unsigned(s);
		if (s < 0) begin
			r = 8'd0;
		end else if (u <= 10'(LEVEL_FINE_TOP)) begin
			r = u[7:0];
		end else if (u <= HALF_DB_LIMIT) begin
			r = LEVEL_FINE_TOP + 8'((u - 10'(LEVEL_FINE_TOP)) >> 1);
		end else begin
			r = LEVEL_MUTE;
		end
		return r;
	endfunction

endpackage

>>> sv/vasd_shifter.sv
// Serial frame shifter: holds the sent code and drives clock, data and load pins.
module vasd_shifter
	import vasd_pkg::*;
#(
	parameter int FRAME_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  vasd_shift_ctrl_t ctrl,
	output vasd_shift_stat_t stat_next
);

	localparam int STEP_W = $clog2(2 * FRAME_BITS + 2);
	localparam int BIT_W  = STEP_W - 1;
	localparam int IDX_W  = $clog2(FRAME_BITS);
	localparam logic [STEP_W-1:0] STEP_STOP = STEP_W'(2 * FRAME_BITS);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(2 * FRAME_BITS + 1);
	localparam logic [BIT_W-1:0]  BIT_MSB   = BIT_W'(FRAME_BITS - 1);
	localparam logic [BIT_W-1:0]  BIT_COUNT = BIT_W'(FRAME_BITS);

	logic [7:0]        sent_code_q;
	logic [STEP_W-1:0] bit_step_q;
	logic              frame_sel_q;
	logic              sending_q;
	logic              clk_pin_q, dat_pin_q, load_pin_q;

	logic [7:0]            sent_code_d;
	logic [STEP_W-1:0]     bit_step_d;
	logic                  frame_sel_d;
	logic                  sending_d;
	logic                  clk_pin_d, dat_pin_d, load_pin_d;
	logic [BIT_W-1:0]      bit_idx;
	logic [BIT_W-1:0]      msb_off;
	logic [FRAME_BITS-1:0] frame;

	assign bit_idx = bit_step_q[STEP_W-1:1];
	assign msb_off = BIT_MSB - bit_idx;
	assign frame   = FRAME_BITS'(sent_code_q)
		| (frame_sel_q ? '0 : FRAME_BITS'(FIRST_FRAME_TAG));

	always_comb begin
		sent_code_d = sent_code_q;
		bit_step_d  = bit_step_q;
		frame_sel_d = frame_sel_q;
		sending_d   = sending_q;
		clk_pin_d   = clk_pin_q;
		dat_pin_d   = dat_pin_q;
		load_pin_d  = load_pin_q;
		if (ctrl.start) begin
			// Keep the bit position: a restart mid-frame mixes old and new code.
			sent_code_d = ctrl.code;
			sending_d   = 1'b1;
		end else if (ctrl.tick && sending_q) begin
			if (!bit_step_q[0]) begin
				if (bit_step_q != STEP_STOP) clk_pin_d = 1'b0;
				if (bit_step_q == '0) load_pin_d = 1'b0;
				if (bit_idx < BIT_COUNT) begin
					dat_pin_d = frame[msb_off[IDX_W-1:0]];
				end else begin
					dat_pin_d = 1'b1;
				end
				bit_step_d = bit_step_q + STEP_W'(1);
			end else begin
				clk_pin_d = 1'b1;
				if (bit_step_q >= STEP_LAST) begin
					load_pin_d  = 1'b1;
					bit_step_d  = '0;
					frame_sel_d = ~frame_sel_q;
					if (frame_sel_q) sending_d = 1'b0;
				end else begin
					bit_step_d = bit_step_q + STEP_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sent_code_q <= '0;
			bit_step_q  <= '0;
			frame_sel_q <= 1'b0;
			sending_q   <= 1'b0;
			clk_pin_q   <= 1'b1;
			dat_pin_q   <= 1'b0;
			load_pin_q  <= 1'b1;
		end else if (advance) begin
			sent_code_q <= sent_code_d;
			bit_step_q  <= bit_step_d;
			frame_sel_q <= frame_sel_d;
			sending_q   <= sending_d;
			clk_pin_q   <= clk_pin_d;
			dat_pin_q   <= dat_pin_d;
			load_pin_q  <= load_pin_d;
		end
	end

	assign stat_next = '{clock_pin: clk_pin_d, data_pin: dat_pin_d,
		load_pin: load_pin_d, busy: sending_d};

endmodule

>>> sv/volume_attenuator_serial_driver_unit.sv
// Top level of the volume attenuator controller with its serial pin driver.
//
// Usage
//   Input stream (s_tvalid/s_tready/s_tdata/s_tuser): one item per tick or
//   command. s_tuser carries the opcode (serial tick, louder, quieter,
//   temporary attenuation, millisecond tick, set level); s_tdata carries the
//   level for set level and the signed half-dB offset for temporary attenuation.
//   Output stream (m_tvalid/m_tready/m_tdata): exactly one item per input
//   item, giving pin levels, busy flag, stored level and temporary flag as
//   they stand after that input item.
//   Config channel (cfg_valid/cfg_ready/cfg_data): writes undo_timeout_ms;
//   always ready, write only while the block is idle.
// Timing
//   An accepted item waits in the input stage until the result slot is free or
//   being drained; the level and shifter logic runs on it and the result loads.
//   Throughput is one item per cycle while m_tready stays high.
// Reset
//   arst_n clears level, flags, counters and the shifter; pins rest with
//   clock high, load high, data low; the timeout returns to 5000 ms.
// Stall
//   A held result keeps the input stage full; one more item is still taken
//   into the input stage, then s_tready drops until the result leaves.
module volume_attenuator_serial_driver_unit
	import vasd_pkg::*;
#(
	parameter int FRAME_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [7:0] level_value, [15:8] relative_half_db
	input  logic [2:0]  s_tuser,   // [2:0] opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [0] clock_pin, [1] data_pin, [2] load_pin,
	                               // [3] busy_res, [11:4] stored_level,
	                               // [12] temp_active, [15:13] zero
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data   // [15:0] undo_timeout_ms
);

	// Input stage
	logic              valid_s1;
	logic [2:0]        op_s1;
	logic [7:0]        lvl_in_s1;
	logic signed [7:0] rel_s1;

	// Block state
	logic [7:0]  level_q;
	logic        temp_q;
	logic [15:0] ms_count_q;
	logic [15:0] timeout_q;

	// Result register
	logic        out_valid_q;
	logic [15:0] out_data_q;

	logic             advance;
	logic [7:0]       level_d;
	logic             temp_d;
	logic [15:0]      ms_count_d;
	logic [15:0]      ms_inc;
	logic signed [9:0] temp_sum;
	vasd_shift_ctrl_t shift_ctrl;
	vasd_shift_stat_t shift_stat;

	// Move the input stage on when the result slot is free or being drained.
	assign advance   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1     <= s_tuser;
			lvl_in_s1 <= s_tdata[7:0];
			rel_s1    <= $signed(s_tdata[15:8]);
		end
	end

	assign temp_sum = $signed({1'b0, code_to_half_db(level_q)}) + 10'(rel_s1);
	assign ms_inc   = (ms_count_q < MS_COUNT_MAX) ? ms_count_q + 16'd1 : ms_count_q;

	// Level, temporary flag and millisecond counter; decide what the shifter does.
	always_comb begin
		level_d    = level_q;
		temp_d     = temp_q;
		ms_count_d = ms_count_q;
		shift_ctrl = '{tick: 1'b0, start: 1'b0, code: level_q};
		case (op_s1)
			OP_SERIAL_TICK: begin
				shift_ctrl.tick = 1'b1;
			end
			OP_LOUDER: begin
				if (level_q != 8'd0) begin
					level_d          = level_q - 8'd1;
					shift_ctrl.start = 1'b1;
					shift_ctrl.code  = level_d;
					temp_d           = 1'b0;
				end
			end
			OP_QUIETER: begin
				if (level_q <= LEVEL_COARSE_TOP) begin
					level_d          = level_q + 8'd1;
					shift_ctrl.start = 1'b1;
					shift_ctrl.code  = level_d;
					temp_d           = 1'b0;
				end
			end
			OP_TEMP_ATTEN: begin
				shift_ctrl.start = 1'b1;
				shift_ctrl.code  = half_db_to_code(temp_sum);
				temp_d           = 1'b1;
				ms_count_d       = '0;
			end
			OP_MS_TICK: begin
				ms_count_d = ms_inc;
				// Revert to the stored level once the timeout has passed.
				if (temp_q && ms_inc > timeout_q) begin
					shift_ctrl.start = 1'b1;
					temp_d           = 1'b0;
				end
			end
			OP_SET_LEVEL: begin
				level_d          = (lvl_in_s1 > LEVEL_MUTE) ? LEVEL_MUTE : lvl_in_s1;
				shift_ctrl.start = 1'b1;
				shift_ctrl.code  = level_d;
				temp_d           = 1'b0;
			end
			default: begin
				// Unused opcodes only report the state.
			end
		endcase
	end

	vasd_shifter #(
		.FRAME_BITS(FRAME_BITS)
	) u_shifter (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.ctrl     (shift_ctrl),
		.stat_next(shift_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q    <= '0;
			temp_q     <= 1'b0;
			ms_count_q <= '0;
			timeout_q  <= TIMEOUT_RESET;
		end else begin
			if (cfg_valid && cfg_ready) timeout_q <= cfg_data;
			if (advance) begin
				level_q    <= level_d;
				temp_q     <= temp_d;
				ms_count_q <= ms_count_d;
			end
		end
	end

	// Result register: load on advance, drop when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {3'b000, temp_d, level_d, shift_stat.busy,
				shift_stat.load_pin, shift_stat.data_pin, shift_stat.clock_pin};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// Stored level never goes past mute.
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= LEVEL_MUTE)
		else $error("stored level above mute");

	// A stalled input stage holds its item.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(op_s1) && $stable(lvl_in_s1))
		else $error("input stage lost an item under stall");

	// Temporary attenuation always leaves the flag set and the counter cleared.
	a_temp_set: assert property (@(posedge clk) disable iff (!arst_n)
		advance && op_s1 == OP_TEMP_ATTEN |=> temp_q && ms_count_q == 16'd0)
		else $error("temporary attenuation did not take effect");

	// The result that loads on advance reports the new stored level.
	a_out_level: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_tvalid && m_tdata[11:4] == level_q && m_tdata[12] == temp_q)
		else $error("result does not match block state");

endmodule

>>> test/volume_attenuator_serial_driver_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the volume attenuator controller and its serial pin driver.
module volume_attenuator_serial_driver_unit_test
	import vasd_pkg::*;
();

	localparam int FRAME_W = 16;
	// Opcodes the block leaves unused; they only report the state.
	localparam logic [2:0] OP_SPARE_LO = 3'd6;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;
	localparam int DIRECTED_ROWS = 25;
	localparam int PHASES = 5;
	localparam int ITEMS_PER_PHASE = 200;
	localparam int DRAIN_CYCLES = 6;
	localparam int HOLD_AFTER = 300;
	localparam int HOLD_CYCLES = 80;

	// One result item as the block reports it.
	typedef struct packed {
		logic       clock_pin;
		logic       data_pin;
		logic       load_pin;
		logic       busy;
		logic [7:0] level;
		logic       temp;
	} pin_report_t;

	// One directed row; want is used only where typed is set.
	typedef struct packed {
		logic [2:0]  op;
		logic [7:0]  lv;
		logic [7:0]  rel;
		logic        typed;
		pin_report_t want;
	} step_row_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic [2:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = '0;

	// Shadow copy of the controller state, advanced on every accepted item.
	logic [15:0] undo_timeout = TIMEOUT_RESET;
	logic [7:0]  level_q = '0;
	logic [7:0]  sent_code = '0;
	logic        temp_flag = 1'b0;
	logic [15:0] ms_count = '0;
	logic [5:0]  bit_step = '0;
	logic        frame_select = 1'b0;
	logic        sending = 1'b0;
	logic        clk_lvl = 1'b1;
	logic        dat_lvl = 1'b0;
	logic        load_lvl = 1'b1;

	pin_report_t expected_reports [$];
	step_row_t   plan [DIRECTED_ROWS];
	int          mismatches = 0;
	int          delivered = 0;
	bit          hold_done = 1'b0;
	bit          no_idle = 1'b0;

	volume_attenuator_serial_driver_unit #(
		.FRAME_BITS(FRAME_W)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard stop far beyond the slowest correct run.
	initial begin
		#2_000_000;
		$display("volume_attenuator_serial_driver_unit_test: done, errors");
		$finish;
	end

	// Code to half-dB: fine steps up to 96, 1 dB steps to 127, mute counts as 100 dB.
	function automatic int code_half_db(input logic [7:0] code);
		if (code <= LEVEL_FINE_TOP) return int'(code);
		if (code <= LEVEL_COARSE_TOP) return 2 * (int'(code) - 96) + 96;
		return int'(HALF_DB_MUTE);
	endfunction

	// Half-dB sum back to a code: clamp below zero, truncate odd half-dB, mute past 78 dB.
	function automatic logic [7:0] half_db_code(input int s);
		if (s < 0) return 8'd0;
		if (s <= 96) return 8'(s);
		if (s <= int'(HALF_DB_LIMIT)) return 8'(96 + (s - 96) / 2);
		return LEVEL_MUTE;
	endfunction

	// Load a new code into the shifter; the bit position carries on.
	task automatic begin_transmit(input logic [7:0] code);
		temp_flag = 1'b0;
		sent_code = code;
		sending = 1'b1;
	endtask

	// Advance the serial pins by one half bit period.
	task automatic shift_half_bit();
		logic [FRAME_W-1:0] word;
		int                 b;
		b = int'(bit_step) >> 1;
		word = FRAME_W'(sent_code);
		if (!frame_select) word = word | FRAME_W'(FIRST_FRAME_TAG);
		if (!sending) return;
		if (!bit_step[0]) begin
			if (bit_step != 6'(2 * FRAME_W)) clk_lvl = 1'b0;
			if (bit_step == 6'd0) load_lvl = 1'b0;
			dat_lvl = (b < FRAME_W) ? word[FRAME_W - 1 - b] : 1'b1;
			bit_step = bit_step + 6'd1;
		end else begin
			clk_lvl = 1'b1;
			if (int'(bit_step) >= 2 * FRAME_W + 1) begin
				// Close the frame: latch, rewind, then second frame or done.
				load_lvl = 1'b1;
				bit_step = '0;
				if (frame_select) begin
					frame_select = 1'b0;
					sending = 1'b0;
				end else begin
					frame_select = 1'b1;
				end
			end else begin
				bit_step = bit_step + 6'd1;
			end
		end
	endtask

	// Apply one command to the shadow state and report the pins after it.
	task automatic advance_attenuator(input logic [2:0] op, input logic [7:0] lv,
		input logic [7:0] rel, output pin_report_t rep);
		case (op)
			OP_SERIAL_TICK: begin
				shift_half_bit();
			end
			OP_LOUDER: begin
				if (level_q != 8'd0) begin
					level_q = level_q - 8'd1;
					begin_transmit(level_q);
				end
			end
			OP_QUIETER: begin
				if (level_q <= LEVEL_COARSE_TOP) begin
					level_q = level_q + 8'd1;
					begin_transmit(level_q);
				end
			end
			OP_TEMP_ATTEN: begin
				begin_transmit(half_db_code(code_half_db(level_q) + int'($signed(rel))));
				temp_flag = 1'b1;
				ms_count = '0;
			end
			OP_MS_TICK: begin
				if (ms_count != MS_COUNT_MAX) ms_count = ms_count + 16'd1;
				if (temp_flag && ms_count > undo_timeout) begin_transmit(level_q);
			end
			OP_SET_LEVEL: begin
				level_q = (lv > LEVEL_MUTE) ? LEVEL_MUTE : lv;
				begin_transmit(level_q);
			end
			default: begin
			end
		endcase
		rep = '{clk_lvl, dat_lvl, load_lvl, sending, level_q, temp_flag};
	endtask

	// Offer one item after a random gap, hold it until taken, then predict its report.
	task automatic send_item(input logic [2:0] op, input logic [7:0] lv, input logic [7:0] rel,
		input logic typed, input pin_report_t want);
		int          gap;
		pin_report_t rep;
		gap = no_idle ? 0 : $urandom_range(0, 7);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {rel, lv};
		do @(posedge clk); while (!s_tready);
		advance_attenuator(op, lv, rel, rep);
		expected_reports.push_back(typed ? want : rep);
	endtask

	// Mostly ticks and well-formed commands, with some spare opcodes and out-of-range levels.
	task automatic send_random_item();
		int         pick;
		logic [2:0] op;
		logic [7:0] lv;
		pick = $urandom_range(0, 99);
		if (pick < 45) op = OP_SERIAL_TICK;
		else if (pick < 57) op = OP_MS_TICK;
		else if (pick < 65) op = OP_LOUDER;
		else if (pick < 73) op = OP_QUIETER;
		else if (pick < 82) op = OP_TEMP_ATTEN;
		else if (pick < 95) op = OP_SET_LEVEL;
		else op = pick[0] ? OP_SPARE_HI : OP_SPARE_LO;
		lv = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 128));
		send_item(op, lv, 8'($urandom), 1'b0, '0);
	endtask

	// Drop valid, wait for every report, then let the pipeline drain.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (expected_reports.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write the undo timeout; the block must be idle.
	task automatic write_timeout(input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		undo_timeout = value;
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// Compare every accepted report with the oldest expectation.
	always @(posedge clk) begin
		pin_report_t want;
		if (m_tvalid && m_tready) begin
			if (expected_reports.size() == 0) begin
				$error("report with no expectation: m_tdata %h", m_tdata);
				mismatches++;
			end else begin
				want = expected_reports.pop_front();
				check_field("clock_pin", want.clock_pin, m_tdata[0]);
				check_field("data_pin", want.data_pin, m_tdata[1]);
				check_field("load_pin", want.load_pin, m_tdata[2]);
				check_field("busy_res", want.busy, m_tdata[3]);
				check_field("stored_level", want.level, m_tdata[11:4]);
				check_field("temp_active", want.temp, m_tdata[12]);
			end
		end
	end

	// Receiver: random stalls, one long hold to back the block up into its input.
	initial begin
		int stall;
		wait (arst_n);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 7);
			if (!hold_done && delivered >= HOLD_AFTER) begin
				stall = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			delivered++;
		end
	end

	initial begin
		logic [15:0] timeout_value;
		// Directed rows: the first ones start from reset and are typed in;
		// the rest cover conversion corners and are predicted.
		plan = '{
			'{OP_LOUDER,      8'd0,   8'h00, 1'b1, '{1'b1, 1'b0, 1'b1, 1'b0, 8'd0,   1'b0}},
			'{OP_QUIETER,     8'd0,   8'h00, 1'b1, '{1'b1, 1'b0, 1'b1, 1'b1, 8'd1,   1'b0}},
			'{OP_SET_LEVEL,   8'd255, 8'h00, 1'b1, '{1'b1, 1'b0, 1'b1, 1'b1, 8'd128, 1'b0}},
			'{OP_QUIETER,     8'd0,   8'h00, 1'b1, '{1'b1, 1'b0, 1'b1, 1'b1, 8'd128, 1'b0}},
			'{OP_SERIAL_TICK, 8'd0,   8'h00, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b1, 8'd128, 1'b0}},
			'{OP_SERIAL_TICK, 8'd0,   8'h00, 1'b1, '{1'b1, 1'b0, 1'b0, 1'b1, 8'd128, 1'b0}},
			'{OP_SERIAL_TICK, 8'd0,   8'h00, 1'b0, '0},
			'{OP_SET_LEVEL,   8'd0,   8'h00, 1'b0, '0},
			'{OP_TEMP_ATTEN,  8'd0,   8'h80, 1'b0, '0},
			'{OP_MS_TICK,     8'd0,   8'h00, 1'b0, '0},
			'{OP_TEMP_ATTEN,  8'd0,   8'h7F, 1'b0, '0},
			'{OP_SET_LEVEL,   8'd128, 8'h00, 1'b0, '0},
			'{OP_TEMP_ATTEN,  8'd0,   8'h7F, 1'b0, '0},
			'{OP_TEMP_ATTEN,  8'd0,   8'h80, 1'b0, '0},
			'{OP_SET_LEVEL,   8'd96,  8'h00, 1'b0, '0},
			'{OP_TEMP_ATTEN,  8'd0,   8'd60, 1'b0, '0},
			'{OP_TEMP_ATTEN,  8'd0,   8'd61, 1'b0, '0},
			'{OP_SET_LEVEL,   8'd127, 8'h00, 1'b0, '0},
			'{OP_TEMP_ATTEN,  8'd0,   8'hFF, 1'b0, '0},
			'{OP_TEMP_ATTEN,  8'd0,   8'hFE, 1'b0, '0},
			'{OP_LOUDER,      8'd0,   8'h00, 1'b0, '0},
			'{OP_SPARE_LO,    8'hFF,  8'hFF, 1'b0, '0},
			'{OP_SPARE_HI,    8'hAA,  8'h55, 1'b0, '0},
			'{OP_SET_LEVEL,   8'd129, 8'h00, 1'b0, '0},
			'{OP_MS_TICK,     8'd0,   8'h00, 1'b0, '0}
		};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			send_item(plan[i].op, plan[i].lv, plan[i].rel, plan[i].typed, plan[i].want);
		end

		// Random phases under different timeouts; one phase runs without idling.
		for (int p = 0; p < PHASES; p++) begin
			settle();
			case (p)
				0: timeout_value = 16'd0;
				1: timeout_value = 16'd3;
				2: timeout_value = 16'hFFFF;
				3: timeout_value = 16'($urandom_range(1, 15));
				default: timeout_value = 16'd8;
			endcase
			write_timeout(timeout_value);
			no_idle = (p == 3);
			repeat (ITEMS_PER_PHASE) send_random_item();
		end

		settle();
		if (mismatches == 0) begin
			$display("volume_attenuator_serial_driver_unit_test: done, clean");
		end else begin
			$display("volume_attenuator_serial_driver_unit_test: done, errors");
		end
		$finish;
	end

endmodule

>>> files.f
sv/vasd_pkg.sv
sv/vasd_shifter.sv
sv/volume_attenuator_serial_driver_unit.sv
test/volume_attenuator_serial_driver_unit_test.sv
